// ===== sv/env_sensor_compensation_core_macros.svh =====
// Assertion macros for the sensor compensation core.
// Simulation builds get concurrent assertions; SYNTH builds get empty bodies.
`ifndef ENV_SENSOR_COMPENSATION_CORE_MACROS_SVH
`define ENV_SENSOR_COMPENSATION_CORE_MACROS_SVH
`ifndef SYNTH
// Property must hold on every clock edge outside reset.
`define ESC_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: assertion failed");
// Condition must never be true outside reset.
`define ESC_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("%m: forbidden condition seen");
`else
`define ESC_ASSERT(label, clk, rst_n, prop)
`define ESC_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ===== sv/env_sc_pkg.sv =====
// Shared types, register index codes and constants for the compensation core.
// No dependencies.
package env_sc_pkg;

  localparam int unsigned CfgW   = 48;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned DivW   = 64;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TEMP_CAL    = 3'd0,
    CFG_PRESS_CAL_A = 3'd1,
    CFG_PRESS_CAL_B = 3'd2,
    CFG_PRESS_CAL_C = 3'd3,
    CFG_HUM_CAL_A   = 3'd4,
    CFG_HUM_CAL_B   = 3'd5
  } cfg_idx_e;

  localparam logic [63:0] PTfineOff = 64'd128000;
  localparam logic [63:0] PBase     = 64'd1048576;
  localparam logic [63:0] PScale    = 64'd3125;
  localparam logic [31:0] HTfineOff = 32'd76800;
  localparam logic [31:0] HRoundA   = 32'd16384;
  localparam logic [31:0] HOffC     = 32'd32768;
  localparam logic [31:0] HOffD     = 32'd2097152;
  localparam logic [31:0] HRoundE   = 32'd8192;
  localparam logic [31:0] HMax      = 32'd419430400;

  typedef struct packed {
    logic [31:0] temperature;
    logic [31:0] pressure;
    logic [16:0] humidity;
    logic        divisor_zero;
  } result_t;

  function automatic logic [31:0] asr32(input logic [31:0] v, input int unsigned s);
    return $signed(v) >>> s;
  endfunction

  function automatic logic [63:0] asr64(input logic [63:0] v, input int unsigned s);
    return $signed(v) >>> s;
  endfunction

  function automatic logic [31:0] mul32lo(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    p = {32'd0, a} * {32'd0, b};
    return p[31:0];
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] sx8(input logic [7:0] v);
    return {{24{v[7]}}, v};
  endfunction

  function automatic logic [63:0] sx16w(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  function automatic logic [63:0] sx32w(input logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

endpackage

// ===== sv/env_sc_mul64.sv =====
// Two-stage low-64-bit product built from three 32x32 partial products.
// Depends on nothing; enable freezes both stages.
module env_sc_mul64 (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic [63:0] y_o
);

  logic [63:0] pp0_d, pp1_d, pp2_d;
  logic [63:0] pp0_q;
  logic [31:0] pp1_q, pp2_q;
  logic [63:0] y_q;

  assign pp0_d = {32'd0, a_i[31:0]} * {32'd0, b_i[31:0]};
  assign pp1_d = {32'd0, a_i[31:0]} * {32'd0, b_i[63:32]};
  assign pp2_d = {32'd0, a_i[63:32]} * {32'd0, b_i[31:0]};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pp0_q <= pp0_d;
      pp1_q <= pp1_d[31:0];
      pp2_q <= pp2_d[31:0];
      y_q   <= pp0_q + {pp1_q + pp2_q, 32'd0};
    end
  end

  assign y_o = y_q;

endmodule

// ===== sv/env_sc_dly.sv =====
// Enabled shift-register delay line, N stages of W bits.
// Depends on nothing; cleared by reset.
module env_sc_dly #(
  parameter int unsigned W = 1,
  parameter int unsigned N = 1
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] tap_q [N];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < N; i++) tap_q[i] <= '0;
    end else if (en_i) begin
      tap_q[0] <= d_i;
      for (int i = 1; i < N; i++) tap_q[i] <= tap_q[i-1];
    end
  end

  assign q_o = tap_q[N-1];

endmodule

// ===== sv/env_sc_div.sv =====
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Depends on env_sc_pkg for the step count.
module env_sc_div (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] num_i,
  input  logic [63:0] den_i,
  output logic [63:0] quo_o
);

  localparam int unsigned Steps = env_sc_pkg::DivW;

  logic [63:0] rem_q [Steps];
  logic [63:0] nq_q  [Steps];
  logic [63:0] den_q [Steps];

  for (genvar k = 0; k < Steps; k++) begin : g_step
    logic [63:0] rem_in, nq_in, den_in;
    logic [64:0] sh, diff;
    logic        ge;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign nq_in  = num_i;
      assign den_in = den_i;
    end else begin : g_rest
      assign rem_in = rem_q[k-1];
      assign nq_in  = nq_q[k-1];
      assign den_in = den_q[k-1];
    end

    assign sh   = {rem_in, nq_in[63]};
    assign diff = sh - {1'b0, den_in};
    assign ge   = (sh >= {1'b0, den_in});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? diff[63:0] : sh[63:0];
        nq_q[k]  <= {nq_in[62:0], ge};
        den_q[k] <= den_in;
      end
    end
  end

  assign quo_o = nq_q[Steps-1];

endmodule

// ===== sv/env_sensor_compensation_core.sv =====
// Top level of the temperature / pressure / humidity compensation core.
// Depends on env_sc_pkg, env_sc_mul64, env_sc_dly, env_sc_div and the macro header.
//
//  channel  | direction | handshake                   | payload
//  ---------+-----------+-----------------------------+--------------------------------
//  input    | in        | in_valid_i / in_stall_o     | raw_pressure/temperature/humidity
//  output   | out       | out_valid_o / out_stall_i   | temperature, pressure, humidity,
//           |           |                             | divisor_zero
//  config   | in        | cfg_we_i (no back-pressure) | cfg_index_i, cfg_wdata_i
//
// One transaction per cycle unless the pipe freezes; 85 pipeline stages (s0..s84) from
// input transaction to the result register, set by the 64-stage pressure divider.
// A two-entry output queue keeps the pipe moving while a result waits.
// The pipe freezes (and in_stall_o rises) only with the queue full and a result
// in the last stage. Reset clears valid bits, queue and config registers.
// Config registers are read live by the pipeline stages; write them only while idle.
`include "env_sensor_compensation_core_macros.svh"

module env_sensor_compensation_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input transactions
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [19:0] raw_pressure_i,
  input  logic [19:0] raw_temperature_i,
  input  logic [15:0] raw_humidity_i,
  // result transactions
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [31:0] temperature_o,
  output logic [31:0] pressure_o,
  output logic [16:0] humidity_o,
  output logic        divisor_zero_o,
  // configuration writes
  input  logic        cfg_we_i,
  input  logic [env_sc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [env_sc_pkg::CfgW-1:0]    cfg_wdata_i
);

  localparam int unsigned PipeDepth = 85;

  // ---------------------------------------------------------------------------
  // Calibration registers
  // ---------------------------------------------------------------------------
  logic [47:0] temp_cal_q, press_cal_a_q, press_cal_b_q, press_cal_c_q;
  logic [31:0] hum_cal_a_q;
  logic [39:0] hum_cal_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_cal_q    <= '0;
      press_cal_a_q <= '0;
      press_cal_b_q <= '0;
      press_cal_c_q <= '0;
      hum_cal_a_q   <= '0;
      hum_cal_b_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (env_sc_pkg::cfg_idx_e'(cfg_index_i))
        env_sc_pkg::CFG_TEMP_CAL:    temp_cal_q    <= cfg_wdata_i;
        env_sc_pkg::CFG_PRESS_CAL_A: press_cal_a_q <= cfg_wdata_i;
        env_sc_pkg::CFG_PRESS_CAL_B: press_cal_b_q <= cfg_wdata_i;
        env_sc_pkg::CFG_PRESS_CAL_C: press_cal_c_q <= cfg_wdata_i;
        env_sc_pkg::CFG_HUM_CAL_A:   hum_cal_a_q   <= cfg_wdata_i[31:0];
        env_sc_pkg::CFG_HUM_CAL_B:   hum_cal_b_q   <= cfg_wdata_i[39:0];
        default: begin end          // unused indexes are dropped
      endcase
    end
  end

  // calibration words
  logic [15:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, h2, h4, h5;
  logic [7:0]  h1, h3, h6;

  assign t1 = temp_cal_q[15:0];
  assign t2 = temp_cal_q[31:16];
  assign t3 = temp_cal_q[47:32];
  assign p1 = press_cal_a_q[15:0];
  assign p2 = press_cal_a_q[31:16];
  assign p3 = press_cal_a_q[47:32];
  assign p4 = press_cal_b_q[15:0];
  assign p5 = press_cal_b_q[31:16];
  assign p6 = press_cal_b_q[47:32];
  assign p7 = press_cal_c_q[15:0];
  assign p8 = press_cal_c_q[31:16];
  assign p9 = press_cal_c_q[47:32];
  assign h1 = hum_cal_a_q[7:0];
  assign h2 = hum_cal_a_q[23:8];
  assign h3 = hum_cal_a_q[31:24];
  assign h4 = hum_cal_b_q[15:0];
  assign h5 = hum_cal_b_q[31:16];
  assign h6 = hum_cal_b_q[39:32];

  // ---------------------------------------------------------------------------
  // Pipeline control: every stage moves together on adv
  // ---------------------------------------------------------------------------
  logic adv, v_last, push, pop;
  logic [1:0] cnt_q;

  assign adv        = !((cnt_q == 2'd2) && v_last);
  assign in_stall_o = !adv;
  assign push       = adv && v_last;
  assign pop        = out_valid_o && !out_stall_i;

  env_sc_dly #(.W(1), .N(PipeDepth)) u_valid (
    .clk_i, .rst_ni, .en_i(adv), .d_i(in_valid_i), .q_o(v_last)
  );

  // s0: input capture
  logic [19:0] s0_p_q, s0_t_q;
  logic [15:0] s0_h_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_p_q <= raw_pressure_i;
      s0_t_q <= raw_temperature_i;
      s0_h_q <= raw_humidity_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Temperature, s1..s4 (32-bit wrap)
  // ---------------------------------------------------------------------------
  logic [31:0] tx, ty;
  logic [31:0] s1_mx_q, s1_yy_q, s2_a1_q, s2_m3_q, s3_tf_q, tf5;
  logic [31:0] s4_temp_q, s4_vh_q;
  logic [63:0] s4_v1_q;

  assign tx  = {15'd0, s0_t_q[19:3]} - {15'd0, t1, 1'b0};
  assign ty  = {16'd0, s0_t_q[19:4]} - {16'd0, t1};
  assign tf5 = s3_tf_q + {s3_tf_q[29:0], 2'b00};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_mx_q   <= env_sc_pkg::mul32lo(tx, env_sc_pkg::sx16(t2));
      s1_yy_q   <= env_sc_pkg::mul32lo(ty, ty);
      s2_a1_q   <= env_sc_pkg::asr32(s1_mx_q, 11);
      s2_m3_q   <= env_sc_pkg::mul32lo(env_sc_pkg::asr32(s1_yy_q, 12),
                                       env_sc_pkg::sx16(t3));
      s3_tf_q   <= s2_a1_q + env_sc_pkg::asr32(s2_m3_q, 14);
      s4_temp_q <= env_sc_pkg::asr32(tf5 + 32'd128, 8);
      s4_v1_q   <= env_sc_pkg::sx32w(s3_tf_q) - env_sc_pkg::PTfineOff;
      s4_vh_q   <= s3_tf_q - env_sc_pkg::HTfineOff;
    end
  end

  // ---------------------------------------------------------------------------
  // Humidity, s5..s11 (32-bit wrap)
  // ---------------------------------------------------------------------------
  logic [15:0] s4_h;
  logic [31:0] s5_ha_q, s5_b6_q, s5_c3_q, s6_a_q, s6_bc_q, s7_a_q, s7_dh_q;
  logic [31:0] s8_ae_q, s9_ae_q, s9_ss_q, s10_ae_q, s10_sh_q, hv, hv_clamp;
  logic [16:0] s11_hum_q;

  env_sc_dly #(.W(16), .N(4)) u_dly_h (
    .clk_i, .rst_ni, .en_i(adv), .d_i(s0_h_q), .q_o(s4_h)
  );

  assign hv = s10_ae_q - env_sc_pkg::asr32(s10_sh_q, 4);

  always_comb begin
    hv_clamp = hv;
    if (hv[31]) begin
      hv_clamp = '0;
    end else if (hv > env_sc_pkg::HMax) begin
      hv_clamp = env_sc_pkg::HMax;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // h4 << 20 keeps only the low 12 bits of h4
      s5_ha_q  <= {2'b00, s4_h, 14'd0} - {h4[11:0], 20'd0}
                  - env_sc_pkg::mul32lo(env_sc_pkg::sx16(h5), s4_vh_q)
                  + env_sc_pkg::HRoundA;
      s5_b6_q  <= env_sc_pkg::mul32lo(s4_vh_q, env_sc_pkg::sx8(h6));
      s5_c3_q  <= env_sc_pkg::mul32lo(s4_vh_q, {24'd0, h3});
      s6_a_q   <= env_sc_pkg::asr32(s5_ha_q, 15);
      s6_bc_q  <= env_sc_pkg::mul32lo(env_sc_pkg::asr32(s5_b6_q, 10),
                    env_sc_pkg::asr32(s5_c3_q, 11) + env_sc_pkg::HOffC);
      s7_a_q   <= s6_a_q;
      s7_dh_q  <= env_sc_pkg::mul32lo(env_sc_pkg::asr32(s6_bc_q, 10) + env_sc_pkg::HOffD,
                    env_sc_pkg::sx16(h2)) + env_sc_pkg::HRoundE;
      s8_ae_q  <= env_sc_pkg::mul32lo(s7_a_q, env_sc_pkg::asr32(s7_dh_q, 14));
      s9_ae_q  <= s8_ae_q;
      s9_ss_q  <= env_sc_pkg::mul32lo(env_sc_pkg::asr32(s8_ae_q, 15),
                                      env_sc_pkg::asr32(s8_ae_q, 15));
      s10_ae_q <= s9_ae_q;
      s10_sh_q <= env_sc_pkg::mul32lo(env_sc_pkg::asr32(s9_ss_q, 7), {24'd0, h1});
      s11_hum_q <= hv_clamp[28:12];
    end
  end

  // ---------------------------------------------------------------------------
  // Pressure, s5..s84 (64-bit wrap)
  // ---------------------------------------------------------------------------
  logic [63:0] s6_sq, s6_m5, s6_m2, s8_v2a, s8_m3, s8_m5, s8_m2;
  logic [63:0] s9_v2_q, s9_x_q, s11_px, s11_v2, s11_pb;
  logic [19:0] s11_p;
  logic [63:0] s12_den_q, s12_pre_q, s13_den_q, s13_num_q;
  logic [63:0] s14_mn_q, s14_md_q;
  logic        s14_neg_q, s14_dz_q, s78_neg, s83_dz;
  logic [63:0] s78_q, s79_p_q, s81_p, s81_r, s81_t9, s81_m8;
  logic [63:0] s83_p, s83_m8, s83_t9r, pp;

  env_sc_mul64 u_mul_sq (.clk_i, .en_i(adv), .a_i(s4_v1_q), .b_i(s4_v1_q), .y_o(s6_sq));
  env_sc_mul64 u_mul_p5 (.clk_i, .en_i(adv), .a_i(s4_v1_q),
                         .b_i(env_sc_pkg::sx16w(p5)), .y_o(s6_m5));
  env_sc_mul64 u_mul_p2 (.clk_i, .en_i(adv), .a_i(s4_v1_q),
                         .b_i(env_sc_pkg::sx16w(p2)), .y_o(s6_m2));
  env_sc_mul64 u_mul_p6 (.clk_i, .en_i(adv), .a_i(s6_sq),
                         .b_i(env_sc_pkg::sx16w(p6)), .y_o(s8_v2a));
  env_sc_mul64 u_mul_p3 (.clk_i, .en_i(adv), .a_i(s6_sq),
                         .b_i(env_sc_pkg::sx16w(p3)), .y_o(s8_m3));

  env_sc_dly #(.W(64), .N(2)) u_dly_m5 (
    .clk_i, .rst_ni, .en_i(adv), .d_i(s6_m5), .q_o(s8_m5)
  );
  env_sc_dly #(.W(64), .N(2)) u_dly_m2 (
    .clk_i, .rst_ni, .en_i(adv), .d_i(s6_m2), .q_o(s8_m2)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s9_v2_q <= s8_v2a + {s8_m5[46:0], 17'd0} + {{13{p4[15]}}, p4, 35'd0};
      s9_x_q  <= {16'd0, 1'b1, 47'd0} + env_sc_pkg::asr64(s8_m3, 8)
                 + {s8_m2[51:0], 12'd0};
    end
  end

  env_sc_mul64 u_mul_p1 (.clk_i, .en_i(adv), .a_i(s9_x_q),
                         .b_i({48'd0, p1}), .y_o(s11_px));
  env_sc_dly #(.W(64), .N(2)) u_dly_v2 (
    .clk_i, .rst_ni, .en_i(adv), .d_i(s9_v2_q), .q_o(s11_v2)
  );
  env_sc_dly #(.W(20), .N(11)) u_dly_p (
    .clk_i, .rst_ni, .en_i(adv), .d_i(s0_p_q), .q_o(s11_p)
  );

  assign s11_pb = env_sc_pkg::PBase - {44'd0, s11_p};

  // divisor, numerator, then sign split ahead of the unsigned divider
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s12_den_q <= env_sc_pkg::asr64(s11_px, 33);
      s12_pre_q <= {s11_pb[32:0], 31'd0} - s11_v2;
      s13_den_q <= s12_den_q;
      s13_num_q <= s12_pre_q * env_sc_pkg::PScale;
      s14_mn_q  <= s13_num_q[63] ? (64'd0 - s13_num_q) : s13_num_q;
      s14_md_q  <= s13_den_q[63] ? (64'd0 - s13_den_q) : s13_den_q;
      s14_neg_q <= s13_num_q[63] ^ s13_den_q[63];
      s14_dz_q  <= (s13_den_q == 64'd0);
    end
  end

  env_sc_div u_div (
    .clk_i, .en_i(adv), .num_i(s14_mn_q), .den_i(s14_md_q), .quo_o(s78_q)
  );
  env_sc_dly #(.W(1), .N(64)) u_dly_neg (
    .clk_i, .rst_ni, .en_i(adv), .d_i(s14_neg_q), .q_o(s78_neg)
  );
  env_sc_dly #(.W(1), .N(69)) u_dly_dz (
    .clk_i, .rst_ni, .en_i(adv), .d_i(s14_dz_q), .q_o(s83_dz)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s79_p_q <= s78_neg ? (64'd0 - s78_q) : s78_q;
    end
  end

  // second-order correction: p9 * (p >> 13)^2 and p8 * p
  env_sc_mul64 u_mul_p9 (.clk_i, .en_i(adv), .a_i(env_sc_pkg::sx16w(p9)),
                         .b_i(env_sc_pkg::asr64(s79_p_q, 13)), .y_o(s81_t9));
  env_sc_mul64 u_mul_p8 (.clk_i, .en_i(adv), .a_i(env_sc_pkg::sx16w(p8)),
                         .b_i(s79_p_q), .y_o(s81_m8));
  env_sc_dly #(.W(64), .N(2)) u_dly_p81 (
    .clk_i, .rst_ni, .en_i(adv), .d_i(s79_p_q), .q_o(s81_p)
  );

  assign s81_r = env_sc_pkg::asr64(s81_p, 13);

  env_sc_mul64 u_mul_r (.clk_i, .en_i(adv), .a_i(s81_t9), .b_i(s81_r), .y_o(s83_t9r));
  env_sc_dly #(.W(64), .N(2)) u_dly_p83 (
    .clk_i, .rst_ni, .en_i(adv), .d_i(s81_p), .q_o(s83_p)
  );
  env_sc_dly #(.W(64), .N(2)) u_dly_m8 (
    .clk_i, .rst_ni, .en_i(adv), .d_i(s81_m8), .q_o(s83_m8)
  );

  assign pp = env_sc_pkg::asr64(s83_p + env_sc_pkg::asr64(s83_t9r, 25)
                                + env_sc_pkg::asr64(s83_m8, 19), 8)
              + {{44{p7[15]}}, p7, 4'd0};

  // ---------------------------------------------------------------------------
  // Align temperature and humidity with the pressure result, s84 register
  // ---------------------------------------------------------------------------
  logic [31:0] s83_temp;
  logic [16:0] s83_hum;
  env_sc_pkg::result_t res_q;

  env_sc_dly #(.W(32), .N(79)) u_dly_temp (
    .clk_i, .rst_ni, .en_i(adv), .d_i(s4_temp_q), .q_o(s83_temp)
  );
  env_sc_dly #(.W(17), .N(72)) u_dly_hum (
    .clk_i, .rst_ni, .en_i(adv), .d_i(s11_hum_q), .q_o(s83_hum)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q.temperature  <= s83_temp;
      res_q.pressure     <= s83_dz ? 32'd0 : pp[31:0];
      res_q.humidity     <= s83_hum;
      res_q.divisor_zero <= s83_dz;
    end
  end

  // ---------------------------------------------------------------------------
  // Two-entry output queue
  // ---------------------------------------------------------------------------
  env_sc_pkg::result_t head_q, tail_q;
  logic push_head;

  assign push_head = push && ((cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_head) begin
      head_q <= res_q;
    end else if (pop) begin
      head_q <= tail_q;
    end
    if (push && !push_head) begin
      tail_q <= res_q;
    end
  end

  assign out_valid_o    = (cnt_q != 2'd0);
  assign temperature_o  = head_q.temperature;
  assign pressure_o     = head_q.pressure;
  assign humidity_o     = head_q.humidity;
  assign divisor_zero_o = head_q.divisor_zero;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `ESC_ASSERT(a_dz_forces_zero, clk_i, rst_ni, out_valid_o && divisor_zero_o |-> pressure_o == 32'd0)
  `ESC_ASSERT(a_hum_in_range, clk_i, rst_ni, out_valid_o |-> humidity_o <= 17'd102400)
  `ESC_ASSERT_NEVER(a_queue_overrun, clk_i, rst_ni, push && (cnt_q == 2'd2) && !pop)
  `ESC_ASSERT(a_stall_cause, clk_i, rst_ni, in_stall_o |-> (cnt_q == 2'd2) && v_last)
  `ESC_ASSERT(a_pop_keeps_tail, clk_i, rst_ni, pop && (cnt_q == 2'd2) |=> out_valid_o)

endmodule
